// ===== src/nwl_pkg.sv =====
package nwl_pkg;

  localparam int TrackDepth = 1024;
  localparam int IdxW = 10;
  localparam int MinSection = 4;
  localparam int LenW = 11;
  localparam int LookW = 31;
  localparam int CoordW = 32;
  localparam int DiffW = 33;
  localparam int SqW = 64;
  localparam int DistW = 65;
  localparam int RootW = 33;
  localparam int SumW = 48;
  localparam int CfgW = 31;

  localparam logic [0:0] CfgTrackLength = 1'd0;
  localparam logic [0:0] CfgLookahead = 1'd1;

  localparam logic OpLoad = 1'b0;
  localparam logic OpQuery = 1'b1;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic walk_start;
    logic walk_step;
    logic root_start;
    logic walk_add;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic walk_done;
    logic root_done;
  } status_t;

endpackage

// ===== src/nwl_if.sv =====
interface nwl_in_if;
  logic valid;
  logic ready;
  logic operation;
  logic [nwl_pkg::IdxW-1:0] point_index;
  logic signed [nwl_pkg::CoordW-1:0] pos_x;
  logic signed [nwl_pkg::CoordW-1:0] pos_y;
  modport source (output valid, operation, point_index, pos_x, pos_y, input ready);
  modport sink (input valid, operation, point_index, pos_x, pos_y, output ready);
endinterface

interface nwl_out_if;
  logic valid;
  logic ready;
  logic [nwl_pkg::IdxW-1:0] section_start;
  logic [nwl_pkg::IdxW-1:0] section_end;
  modport source (output valid, section_start, section_end, input ready);
  modport sink (input valid, section_start, section_end, output ready);
endinterface

// ===== src/nearest_waypoint_lookahead_window.sv =====
// Load words (operation 0) each write one waypoint. A query word scans
// track_length points (held between 5 and 1024) at one point per cycle through
// the waypoint memory, then walks forward with a bit-serial square root per
// segment, and the result word of a query is registered when the walk ends.
// No new word is taken while a query runs or while its result word waits.
module nearest_waypoint_lookahead_window (
  input  logic clk,
  input  logic rst,
  nwl_in_if.sink in_ch,
  nwl_out_if.source out_ch,
  input  logic cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [nwl_pkg::CfgW-1:0] cfg_data
);

  nwl_pkg::cmd_t cmd;
  nwl_pkg::status_t status;
  logic [nwl_pkg::LenW-1:0] track_length;
  logic [nwl_pkg::LookW-1:0] lookahead_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      track_length <= nwl_pkg::LenW'(5);
      lookahead_length <= nwl_pkg::LookW'(983040);
    end else if (cfg_we) begin
      if (cfg_index == nwl_pkg::CfgTrackLength)
        track_length <= cfg_data[nwl_pkg::LenW-1:0];
      else if (cfg_index == nwl_pkg::CfgLookahead)
        lookahead_length <= cfg_data[nwl_pkg::LookW-1:0];
    end
  end

  nwl_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_op(in_ch.operation), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .status(status), .cmd(cmd)
  );

  nwl_dp u_dp (
    .clk(clk), .rst(rst), .point_index(in_ch.point_index),
    .pos_x(in_ch.pos_x), .pos_y(in_ch.pos_y),
    .track_length(track_length), .lookahead_length(lookahead_length),
    .cmd(cmd), .status(status),
    .section_start(out_ch.section_start), .section_end(out_ch.section_end)
  );

endmodule

// ===== src/nwl_ctrl.sv =====
module nwl_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_op,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  nwl_pkg::status_t status,
  output nwl_pkg::cmd_t cmd
);

  localparam logic [2:0] Idle = 3'd0;
  localparam logic [2:0] Scan = 3'd1;
  localparam logic [2:0] ScanLast = 3'd2;
  localparam logic [2:0] WalkChk = 3'd3;
  localparam logic [2:0] Fetch = 3'd4;
  localparam logic [2:0] Root = 3'd5;
  localparam logic [2:0] Done = 3'd6;

  logic [2:0] state, state_next;
  logic ovalid, ovalid_next;

  assign in_ready = (state == Idle) && !ovalid;
  assign out_valid = ovalid;

  always_comb begin
    state_next = state;
    ovalid_next = ovalid && !out_ready;
    cmd = '0;
    case (state)
      Idle: begin
        if (in_valid && in_ready) begin
          if (in_op == nwl_pkg::OpLoad) cmd.load = 1'b1;
          else begin
            cmd.scan_start = 1'b1;
            state_next = Scan;
          end
        end
      end
      Scan: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) state_next = ScanLast;
      end
      ScanLast: begin
        cmd.walk_start = 1'b1;
        state_next = WalkChk;
      end
      WalkChk: begin
        if (status.walk_done) state_next = Done;
        else begin
          cmd.walk_step = 1'b1;
          state_next = Fetch;
        end
      end
      Fetch: begin
        cmd.root_start = 1'b1;
        state_next = Root;
      end
      Root: begin
        if (status.root_done) begin
          cmd.walk_add = 1'b1;
          state_next = WalkChk;
        end
      end
      Done: begin
        cmd.finish = 1'b1;
        ovalid_next = 1'b1;
        state_next = Idle;
      end
      default: state_next = Idle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= Idle;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      ovalid <= ovalid_next;
    end
  end

  a_finish_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid) else $error("result not presented");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != Idle) |-> !in_ready) else $error("accept while busy");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");

endmodule

// ===== src/nwl_dp.sv =====
module nwl_dp (
  input  logic clk,
  input  logic rst,
  input  logic [nwl_pkg::IdxW-1:0] point_index,
  input  logic signed [nwl_pkg::CoordW-1:0] pos_x,
  input  logic signed [nwl_pkg::CoordW-1:0] pos_y,
  input  logic [nwl_pkg::LenW-1:0] track_length,
  input  logic [nwl_pkg::LookW-1:0] lookahead_length,
  input  nwl_pkg::cmd_t cmd,
  output nwl_pkg::status_t status,
  output logic [nwl_pkg::IdxW-1:0] section_start,
  output logic [nwl_pkg::IdxW-1:0] section_end
);

  logic signed [nwl_pkg::CoordW-1:0] mem_x [nwl_pkg::TrackDepth];
  logic signed [nwl_pkg::CoordW-1:0] mem_y [nwl_pkg::TrackDepth];
  logic signed [nwl_pkg::CoordW-1:0] rd_x, rd_y, px, py;
  logic signed [nwl_pkg::CoordW-1:0] mem_x_hold_x, mem_x_hold_y;
  logic [nwl_pkg::IdxW-1:0] rd_addr;
  logic [nwl_pkg::LenW-1:0] len_pts, scan_i, front, best;
  logic [nwl_pkg::LenW-1:0] rd_idx;
  logic [nwl_pkg::DistW-1:0] best_d, sq_d;
  logic signed [nwl_pkg::DiffW-1:0] dx, dy;
  logic [nwl_pkg::CoordW-1:0] ax, ay;
  logic [nwl_pkg::SqW-1:0] sqx, sqy;
  logic [nwl_pkg::SumW-1:0] sum;
  logic [nwl_pkg::DistW-1:0] root_v, rem;
  logic [nwl_pkg::RootW-1:0] root;
  logic [5:0] rbit;
  logic rbusy;
  logic [nwl_pkg::DistW+1:0] rem_sh;
  logic [nwl_pkg::RootW-1:0] root_next;
  logic [nwl_pkg::DistW-1:0] rem_next;
  logic [1:0] pair;
  logic [nwl_pkg::LenW-1:0] s_end, s_beg, e_ext;

  function automatic logic signed [nwl_pkg::DiffW-1:0] DiffW_sext(
    input logic signed [nwl_pkg::CoordW-1:0] v);
    return {v[nwl_pkg::CoordW-1], v};
  endfunction

  always_comb begin
    if (track_length > nwl_pkg::LenW'(nwl_pkg::TrackDepth))
      len_pts = nwl_pkg::LenW'(nwl_pkg::TrackDepth);
    else if (track_length < nwl_pkg::LenW'(nwl_pkg::MinSection + 1))
      len_pts = nwl_pkg::LenW'(nwl_pkg::MinSection + 1);
    else len_pts = track_length;
  end

  // Scanning reads point i this cycle and compares it next cycle.
  always_comb begin
    if (cmd.scan_start) rd_addr = '0;
    else if (cmd.scan_step) rd_addr = scan_i[nwl_pkg::IdxW-1:0];
    else if (cmd.walk_step) rd_addr = front[nwl_pkg::IdxW-1:0] + nwl_pkg::IdxW'(1);
    else rd_addr = '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem_x[point_index] <= pos_x;
      mem_y[point_index] <= pos_y;
    end
    rd_x <= mem_x[rd_addr];
    rd_y <= mem_y[rd_addr];
  end

  // The point at front is read through a second port into a register.
  always_ff @(posedge clk) begin
    mem_x_hold_x <= mem_x[front[nwl_pkg::IdxW-1:0]];
    mem_x_hold_y <= mem_y[front[nwl_pkg::IdxW-1:0]];
  end

  // Distance uses either the vehicle or the point at front as reference.
  always_comb begin
    if (cmd.root_start) begin
      dx = DiffW_sext(rd_x) - DiffW_sext(mem_x_hold_x);
      dy = DiffW_sext(rd_y) - DiffW_sext(mem_x_hold_y);
    end else begin
      dx = DiffW_sext(px) - DiffW_sext(rd_x);
      dy = DiffW_sext(py) - DiffW_sext(rd_y);
    end
    ax = dx[nwl_pkg::DiffW-1] ? nwl_pkg::CoordW'(-dx) : nwl_pkg::CoordW'(dx);
    ay = dy[nwl_pkg::DiffW-1] ? nwl_pkg::CoordW'(-dy) : nwl_pkg::CoordW'(dy);
  end

  // A difference of two 32-bit values never exceeds 2^32 - 1 in magnitude.
  assign sqx = ax * ax;
  assign sqy = ay * ay;
  assign sq_d = nwl_pkg::DistW'(sqx) + nwl_pkg::DistW'(sqy);

  assign status.scan_last = (scan_i == len_pts);
  assign status.walk_done = (sum >= nwl_pkg::SumW'(lookahead_length))
                         || (front + nwl_pkg::LenW'(1) >= len_pts);
  assign status.root_done = rbusy && (rbit == 6'd0);

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      px <= pos_x;
      py <= pos_y;
      scan_i <= nwl_pkg::LenW'(1);
      rd_idx <= '0;
      best_d <= '1;
      best <= '0;
    end
    if (cmd.scan_step) begin
      rd_idx <= scan_i;
      scan_i <= scan_i + nwl_pkg::LenW'(1);
      if (rd_idx == '0 || sq_d < best_d) begin
        best_d <= sq_d;
        best <= rd_idx;
      end
    end
    if (cmd.walk_start) begin
      front <= best;
      sum <= '0;
    end
    if (cmd.root_start) begin
      root_v <= sq_d;
      rbit <= 6'd33;
    end else if (rbusy && rbit != 6'd0) begin
      rbit <= rbit - 6'd1;
    end
    if (cmd.walk_add) begin
      sum <= sum + nwl_pkg::SumW'(root_next);
      front <= front + nwl_pkg::LenW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rbusy <= 1'b0;
    end else if (cmd.root_start) begin
      rbusy <= 1'b1;
    end else if (rbusy && rbit == 6'd0) begin
      rbusy <= 1'b0;
    end
  end

  // Bit-pair digit recurrence: one result bit per cycle. The
  // last bit is taken straight from the recurrence when the sum is updated.
  always_comb begin
    pair = 2'(root_v >> {rbit, 1'b0});
    rem_sh = {rem, pair};
    if (rem_sh >= {1'b0, root, 2'b01}) begin
      rem_next = nwl_pkg::DistW'(rem_sh - {1'b0, root, 2'b01});
      root_next = {root[nwl_pkg::RootW-2:0], 1'b1};
    end else begin
      rem_next = nwl_pkg::DistW'(rem_sh);
      root_next = {root[nwl_pkg::RootW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.root_start) begin
      rem <= '0;
      root <= '0;
    end else if (rbusy && !(rbit == 6'd0)) begin
      rem <= rem_next;
      root <= root_next;
    end
  end

  always_comb begin
    s_beg = best;
    s_end = front;
    e_ext = best + nwl_pkg::LenW'(nwl_pkg::MinSection);
    if (front - best < nwl_pkg::LenW'(nwl_pkg::MinSection)) s_end = e_ext;
    if (s_end >= len_pts) begin
      s_beg = '0;
      s_end = nwl_pkg::LenW'(nwl_pkg::MinSection);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      section_start <= s_beg[nwl_pkg::IdxW-1:0];
      section_end <= s_end[nwl_pkg::IdxW-1:0];
    end
  end

endmodule
